[src/integer_alu_with_register_file_assert.svh]
// Assertion macros used by the checker file.
`ifndef INTEGER_ALU_WITH_REGISTER_FILE_ASSERT_SVH
`define INTEGER_ALU_WITH_REGISTER_FILE_ASSERT_SVH
// Implication checked on every clock, disabled in reset.
`define IALU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define IALU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/ialu_pkg.sv]
// ----------------------------------------------------------------------------
// ialu_pkg
// Opcodes, sequencer states and shared types of the integer ALU.
// ----------------------------------------------------------------------------
package ialu_pkg;
  localparam int unsigned WordW = 32;

  typedef enum logic [4:0] {
    OP_EQ = 5'd0, OP_NE = 5'd1, OP_GT = 5'd2, OP_GE = 5'd3, OP_LT = 5'd4,
    OP_LE = 5'd5, OP_NOT = 5'd6, OP_AND = 5'd7, OP_OR = 5'd8, OP_XOR = 5'd9,
    OP_BNOT = 5'd10, OP_SHL = 5'd11, OP_ADD = 5'd12, OP_SUB = 5'd13,
    OP_MUL = 5'd14, OP_DIV = 5'd15, OP_MOD = 5'd16, OP_NEG = 5'd17,
    OP_ABS = 5'd18, OP_MIN = 5'd19, OP_MAX = 5'd20, OP_TOBOOL = 5'd21,
    OP_LEA = 5'd22, OP_MOVIMM = 5'd23, OP_MOVREG = 5'd24
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_ITER, ST_FIX, ST_OUT
  } state_t;

  // algorithm run by the shared iterative unit
  typedef enum logic [1:0] {
    UK_MUL, UK_DIV, UK_SHL, UK_SHR
  } ukind_t;

  typedef logic [WordW-1:0] word_t;
endpackage

[src/ialu_if.sv]
// ----------------------------------------------------------------------------
// ialu_in_if / ialu_out_if
// Valid/ready request channels of the integer ALU.
// ----------------------------------------------------------------------------
interface ialu_in_if;
  logic valid;
  logic ready;
  logic [4:0] req_type;
  logic [3:0] dest_index;
  logic [3:0] source_index;
  logic uses_immediate;
  logic signed [31:0] immediate;
  modport source (output valid, req_type, dest_index, source_index, uses_immediate,
                  immediate, input ready);
  modport sink (input valid, req_type, dest_index, source_index, uses_immediate,
                immediate, output ready);
endinterface

interface ialu_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] written_value;
  logic [3:0] written_index;
  logic error_code;
  modport source (output valid, written_value, written_index, error_code, input ready);
  modport sink (input valid, written_value, written_index, error_code, output ready);
endinterface

[src/integer_alu_with_register_file.sv]
// Integer ALU over a register file. A request passes through the accepting
// cycle, register read, execute, write-back and the output cycle, and the
// result shows in the output cycle. Multiply and divide/modulo add an
// iteration phase in the shared shift-add/restoring unit (one-bit steps and
// a done cycle); a shift by less than 32 bits uses the unit as well. Reset
// clears the register file at once. A result waits in the output register
// until taken, and the input stays closed meanwhile.
// ----------------------------------------------------------------------------
// integer_alu_with_register_file
// Sequenced 32-bit integer ALU with a register file and one shared unit.
// ----------------------------------------------------------------------------
module integer_alu_with_register_file
  import ialu_pkg::*;
#(
  parameter int unsigned REGISTER_COUNT = 16
) (
  input logic clk,
  input logic rst_n,
  ialu_in_if.sink    in_ch,
  ialu_out_if.source out_ch
);
  localparam int unsigned IdxW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

  word_t rf_r [REGISTER_COUNT];
  state_t state_r, state_nxt;
  logic [4:0] op_r;
  logic [IdxW-1:0] d_r, s_r;
  logic uimm_r;
  word_t imm_r, a_r, src_r, res_r, res_nxt;
  logic err_r, err_nxt, wr_en;
  logic neg_res_r;
  word_t b;
  logic less_ab, less_ba;
  logic [4:0] pick;
  logic un_start, un_done;
  ukind_t un_kind;
  word_t un_a, un_b, un_lo, un_hi, bneg;
  logic [5:0] un_cnt;
  logic [3:0] ovalid_idx;

  // index wrap modulo register count, as a small table over the 4-bit index
  function automatic logic [IdxW-1:0] slot(input logic [3:0] i);
    logic [IdxW-1:0] r;
    r = '0;
    for (int k = 0; k < 16; k++)
      if (i == 4'(k)) r = IdxW'(k % REGISTER_COUNT);
    return r;
  endfunction

  assign b = uimm_r ? imm_r : src_r;
  assign less_ab = $signed(a_r) < $signed(b);
  assign less_ba = $signed(b) < $signed(a_r);
  assign bneg = 32'd0 - b;
  assign pick = op_r;
  assign in_ch.ready = (state_r == ST_IDLE);

  ialu_seq_unit u_unit (
    .clk, .rst_n, .start(un_start), .kind(un_kind), .opa(un_a), .opb(un_b),
    .count(un_cnt), .done(un_done), .res_lo(un_lo), .res_hi(un_hi)
  );

  // sequencer and result select
  always_comb begin
    state_nxt = state_r; res_nxt = res_r; err_nxt = err_r; wr_en = 1'b0;
    un_start = 1'b0; un_kind = UK_MUL; un_a = a_r; un_b = b; un_cnt = 6'd32;
    case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: begin
        state_nxt = ST_FIX; err_nxt = 1'b0; res_nxt = a_r;
        case (pick)
          OP_EQ: res_nxt = {31'd0, a_r == b};
          OP_NE: res_nxt = {31'd0, a_r != b};
          OP_GT: res_nxt = {31'd0, less_ba};
          OP_GE: res_nxt = {31'd0, !less_ab};
          OP_LT: res_nxt = {31'd0, less_ab};
          OP_LE: res_nxt = {31'd0, !less_ba};
          OP_NOT: res_nxt = ~a_r;
          OP_AND: res_nxt = a_r & b;
          OP_OR: res_nxt = a_r | b;
          OP_XOR: res_nxt = a_r ^ b;
          OP_BNOT: res_nxt = {31'd0, a_r == '0};
          OP_SHL: begin
            if (b != '0 && !b[31]) begin
              if (b >= 32'd32) res_nxt = '0;
              else begin
                un_start = 1'b1; un_kind = UK_SHL; un_cnt = b[5:0]; state_nxt = ST_ITER;
              end
            end else if (bneg >= 32'd32) res_nxt = '0;
            else begin
              un_start = 1'b1; un_kind = UK_SHR; un_cnt = bneg[5:0]; state_nxt = ST_ITER;
            end
          end
          OP_ADD: res_nxt = a_r + b;
          OP_SUB: res_nxt = a_r - b;
          OP_MUL: begin
            un_start = 1'b1; un_kind = UK_MUL; state_nxt = ST_ITER;
          end
          OP_DIV, OP_MOD: begin
            if (b == '0) err_nxt = 1'b1;
            else begin
              un_start = 1'b1; un_kind = UK_DIV; state_nxt = ST_ITER;
              un_a = a_r[31] ? 32'd0 - a_r : a_r;
              un_b = b[31] ? bneg : b;
            end
          end
          OP_NEG: res_nxt = 32'd0 - a_r;
          OP_ABS: res_nxt = a_r[31] ? 32'd0 - a_r : a_r;
          OP_MIN: res_nxt = less_ba ? b : a_r;
          OP_MAX: res_nxt = less_ab ? b : a_r;
          OP_TOBOOL: res_nxt = {31'd0, a_r != '0};
          OP_LEA: res_nxt = uimm_r ? src_r + imm_r : src_r;
          OP_MOVIMM: res_nxt = imm_r;
          OP_MOVREG: res_nxt = src_r;
          default: res_nxt = a_r;
        endcase
      end
      ST_ITER: if (un_done) begin
        state_nxt = ST_FIX;
        case (pick)
          OP_DIV: res_nxt = neg_res_r ? 32'd0 - un_lo : un_lo;
          OP_MOD: res_nxt = a_r[31] ? 32'd0 - un_hi : un_hi;
          default: res_nxt = un_lo;
        endcase
      end
      ST_FIX: begin
        wr_en = 1'b1; state_nxt = ST_OUT;
      end
      ST_OUT: if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state, request capture and register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < REGISTER_COUNT; i++) rf_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) rf_r[d_r] <= res_r;
    end
    if (in_ch.valid && in_ch.ready) begin
      op_r <= in_ch.req_type; d_r <= slot(in_ch.dest_index);
      s_r <= slot(in_ch.source_index); uimm_r <= in_ch.uses_immediate;
      imm_r <= in_ch.immediate;
    end
    if (state_r == ST_READ) begin
      a_r <= rf_r[d_r]; src_r <= rf_r[s_r];
    end
    if (state_r == ST_EXEC) neg_res_r <= a_r[31] ^ b[31];
    res_r <= res_nxt; err_r <= err_nxt;
  end

  assign ovalid_idx = 4'(d_r);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.written_value = res_r;
  assign out_ch.written_index = ovalid_idx;
  assign out_ch.error_code = err_r;
endmodule

[src/ialu_seq_unit.sv]
// ----------------------------------------------------------------------------
// ialu_seq_unit
// Shared iterative unit: shift-add multiply, restoring divide, shift.
// One bit per cycle; kind selects the algorithm.
// ----------------------------------------------------------------------------
module ialu_seq_unit
  import ialu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  ukind_t     kind,
  input  word_t      opa,
  input  word_t      opb,
  input  logic [5:0] count,     // iterations to run
  output logic       done,
  output word_t      res_lo,    // product / quotient / shifted word
  output word_t      res_hi     // remainder
);
  word_t acc_r, acc_nxt, x_r, x_nxt, y_r, y_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  ukind_t kind_r;
  logic [WordW:0] trial;

  always_comb begin
    acc_nxt = acc_r; x_nxt = x_r; y_nxt = y_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r;
    trial = '0;
    if (start) begin
      acc_nxt = '0; x_nxt = opa; y_nxt = opb; cnt_nxt = count; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
        case (kind_r)
          UK_MUL: begin
            // x multiplicand shifts left, y multiplier shifts right
            if (y_r[0]) acc_nxt = acc_r + x_r;
            x_nxt = x_r << 1;
            y_nxt = y_r >> 1;
          end
          UK_DIV: begin
            // acc remainder, x dividend -> quotient, y divisor
            trial = {acc_r, x_r[WordW-1]} - {1'b0, y_r};
            if (!trial[WordW]) begin
              acc_nxt = trial[WordW-1:0];
              x_nxt = {x_r[WordW-2:0], 1'b1};
            end else begin
              acc_nxt = {acc_r[WordW-2:0], x_r[WordW-1]};
              x_nxt = {x_r[WordW-2:0], 1'b0};
            end
          end
          UK_SHL: x_nxt = x_r << 1;
          default: x_nxt = x_r >> 1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt; x_r <= x_nxt; y_r <= y_nxt;
    if (start) kind_r <= kind;
  end

  assign done = busy_r && (cnt_r == 6'd0);
  assign res_lo = (kind_r == UK_MUL) ? acc_r : x_r;
  assign res_hi = acc_r;
endmodule

[src/ialu_checker.sv]
// ----------------------------------------------------------------------------
// ialu_checker
// Port-level checks on request sequencing of the integer ALU.
// ----------------------------------------------------------------------------
`include "integer_alu_with_register_file_assert.svh"
module ialu_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_value
);
  // never accepting while a result is pending
  `IALU_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  // acceptance closes the input until the result leaves
  `IALU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // stalled result holds its value
  `IALU_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_value))
endmodule

bind integer_alu_with_register_file ialu_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_value(out_ch.written_value)
);

[verif/integer_alu_with_register_file_tb.sv]
// ----------------------------------------------------------------------------
// integer_alu_with_register_file_tb
// Self-checking bench: directed and random instructions go to the ALU, a
// local register-file model predicts each write-back, and every result is
// compared field by field under random stalls on both channels.
// ----------------------------------------------------------------------------
module integer_alu_with_register_file_tb;
  import ialu_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  index;
    logic        err;
  } wb_t;

  logic clk;
  logic rst_n;

  ialu_in_if  in_ch ();
  ialu_out_if out_ch ();

  integer_alu_with_register_file #(.REGISTER_COUNT(16)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  logic [31:0] regs_model [16];
  wb_t         pending_wb [$];
  int          mismatch_count;
  int          result_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_off_cycles;
  int          quiet_cycles;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Signed less-than helper
  function automatic bit s_lt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Predict one write-back and update the model register file
  function automatic wb_t alu_predict(logic [4:0] op, logic [3:0] d, logic [3:0] s,
                                      logic ui, logic [31:0] imm);
    logic [31:0] a, src, b, r, mag, ua, ub, q, rm;
    logic        e;
    wb_t         w;
    a = regs_model[d];
    src = regs_model[s];
    b = ui ? imm : src;
    r = a;
    e = 1'b0;
    case (op)
      OP_EQ:     r = {31'd0, a == b};
      OP_NE:     r = {31'd0, a != b};
      OP_GT:     r = {31'd0, s_lt(b, a)};
      OP_GE:     r = {31'd0, !s_lt(a, b)};
      OP_LT:     r = {31'd0, s_lt(a, b)};
      OP_LE:     r = {31'd0, !s_lt(b, a)};
      OP_NOT:    r = ~a;
      OP_AND:    r = a & b;
      OP_OR:     r = a | b;
      OP_XOR:    r = a ^ b;
      OP_BNOT:   r = {31'd0, a == 0};
      OP_SHL: begin
        if (b != 0 && !b[31]) begin
          r = (b >= 32) ? 32'd0 : a << b;
        end else begin
          mag = -b;
          r = (mag >= 32) ? 32'd0 : a >> mag;
        end
      end
      OP_ADD:    r = a + b;
      OP_SUB:    r = a - b;
      OP_MUL:    r = a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          e = 1'b1;
        end else begin
          ua = a[31] ? -a : a;
          ub = b[31] ? -b : b;
          q = ua / ub;
          rm = ua % ub;
          if (op == OP_MOD) r = a[31] ? -rm : rm;
          else r = (a[31] != b[31]) ? -q : q;
        end
      end
      OP_NEG:    r = -a;
      OP_ABS:    r = a[31] ? -a : a;
      OP_MIN:    r = s_lt(b, a) ? b : a;
      OP_MAX:    r = s_lt(a, b) ? b : a;
      OP_TOBOOL: r = {31'd0, a != 0};
      OP_LEA:    r = ui ? src + imm : src;
      OP_MOVIMM: r = imm;
      OP_MOVREG: r = src;
      default:   r = a;
    endcase
    regs_model[d] = r;
    w.value = r;
    w.index = d;
    w.err = e;
    return w;
  endfunction

  // Send one request, queue its prediction on acceptance; valid stays high
  // until the next request or an idle cycle takes it down
  task automatic send_req(logic [4:0] op, logic [3:0] d, logic [3:0] s, logic ui,
                          logic [31:0] imm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= op;
    in_ch.dest_index <= d;
    in_ch.source_index <= s;
    in_ch.uses_immediate <= ui;
    in_ch.immediate <= imm;
    do @(posedge clk); while (!in_ch.ready);
    pending_wb.push_back(alu_predict(op, d, s, ui, imm));
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  // Result checker
  always @(posedge clk) begin
    wb_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (pending_wb.size() == 0) begin
        report_mismatch("unexpected result", out_ch.written_value, 32'd0);
      end else begin
        w = pending_wb.pop_front();
        if (out_ch.written_value !== w.value)
          report_mismatch("written_value", out_ch.written_value, w.value);
        if (out_ch.written_index !== w.index)
          report_mismatch("written_index", 32'(out_ch.written_index), 32'(w.index));
        if (out_ch.error_code !== w.err)
          report_mismatch("error_code", 32'(out_ch.error_code), 32'(w.err));
      end
    end
  end

  // Receiver ready, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no accepted request or taken result
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(40) - 20;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    // Extremes and special cases
    send_req(OP_MOVIMM, 4'd1, 4'd0, 1'b0, 32'h8000_0000);
    send_req(OP_MOVIMM, 4'd2, 4'd0, 1'b1, 32'hffff_ffff);
    send_req(OP_MOVIMM, 4'd15, 4'd0, 1'b1, 32'h7fff_ffff);
    send_req(OP_MOVREG, 4'd3, 4'd1, 1'b0, 32'd0);
    send_req(OP_DIV, 4'd3, 4'd2, 1'b0, 32'd0);        // most negative by -1
    send_req(OP_MOVREG, 4'd4, 4'd1, 1'b0, 32'd0);
    send_req(OP_MOD, 4'd4, 4'd2, 1'b0, 32'd0);
    send_req(OP_DIV, 4'd1, 4'd0, 1'b1, 32'd0);        // zero divisor
    send_req(OP_MOD, 4'd15, 4'd0, 1'b0, 32'd0);
    send_req(OP_ABS, 4'd1, 4'd0, 1'b0, 32'd0);        // abs wraps
    send_req(OP_MOVIMM, 4'd5, 4'd0, 1'b1, 32'h8765_4321);
    send_req(OP_SHL, 4'd5, 4'd0, 1'b1, 32'd4);
    send_req(OP_SHL, 4'd5, 4'd0, 1'b1, -32'sd8);      // negative: right
    send_req(OP_SHL, 4'd5, 4'd0, 1'b1, 32'd0);
    send_req(OP_SHL, 4'd5, 4'd0, 1'b1, 32'd32);
    send_req(OP_SHL, 4'd15, 4'd0, 1'b1, 32'h8000_0000);
    send_req(OP_LEA, 4'd6, 4'd15, 1'b1, 32'd1);       // lea with an immediate offset
    send_req(5'd25, 4'd6, 4'd0, 1'b1, 32'd1);          // unused opcodes
    send_req(5'd31, 4'd2, 4'd15, 1'b0, 32'hffff_ffff);
    for (int op = 0; op <= OP_MOVREG; op++)
      send_req(op[4:0], 4'd2, 4'd1, 1'b0, 32'd0);
  endtask

  task automatic test_random(int count);
    logic [4:0] op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(19) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(24));
      if ($urandom_range(3) == 0)
        send_req(OP_MOVIMM, 4'($urandom), 4'($urandom), 1'($urandom), pick_word());
      else
        send_req(op, 4'($urandom), 4'($urandom), 1'($urandom), pick_word());
    end
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 300;
    test_random(20);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (pending_wb.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.dest_index = '0;
    in_ch.source_index = '0;
    in_ch.uses_immediate = 1'b0;
    in_ch.immediate = '0;
    out_ch.ready = 1'b0;
    mismatch_count = 0;
    result_count = 0;
    hold_off_cycles = 0;
    quiet_cycles = 0;
    send_idle_pct = 38;
    recv_idle_pct = 64;
    foreach (regs_model[i]) regs_model[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random(600);
    send_idle_pct = 64;
    recv_idle_pct = 38;
    test_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(600);
    drain();

    $display("Ran %0d ALU requests: all opcodes, divide and shift corners, stalls.",
             result_count);
    if (mismatch_count == 0 && pending_wb.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[integer_alu_with_register_file.f]
+incdir+src
src/ialu_pkg.sv
src/ialu_if.sv
src/ialu_seq_unit.sv
src/integer_alu_with_register_file.sv
src/ialu_checker.sv
verif/integer_alu_with_register_file_tb.sv
